// ===== hw/rtl/tcmk_pkg.sv =====
// Shared types, constants and microcode table for the TEA counter-mode keystream unit.
package tcmk_pkg;

  localparam logic [31:0] TeaDelta = 32'h9E37_79B9;

  typedef enum logic [2:0] {
    CFG_KEY0  = 3'd0,
    CFG_KEY1  = 3'd1,
    CFG_KEY2  = 3'd2,
    CFG_KEY3  = 3'd3,
    CFG_NONCE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_V0,
    STEP_V1,
    STEP_EMIT
  } step_e;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_LAST_RND,
    COND_OUT_FREE
  } cond_e;

  // Datapath control, one set per microcode step.
  typedef struct packed {
    logic load;    // take the counter block, sum <= delta
    logic upd;     // apply a half round
    logic sel_v1;  // half round on v1 (and advance sum), else on v0
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t dp;
    logic     emit;  // write the result beat into the output register
    cond_e    cond;  // jump condition
    step_e    go;    // next step when cond holds
    step_e    stay;  // next step otherwise
  } uword_t;

  function automatic uword_t ucode(input step_e step);
    uword_t w;
    w = '{dp: '{load: 1'b0, upd: 1'b0, sel_v1: 1'b0}, emit: 1'b0,
          cond: COND_ALWAYS, go: STEP_IDLE, stay: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.dp.load = 1'b1;
        w.cond    = COND_IN_VALID;
        w.go      = STEP_V0;
        w.stay    = STEP_IDLE;
      end
      STEP_V0: begin
        w.dp.upd = 1'b1;
        w.cond   = COND_ALWAYS;
        w.go     = STEP_V1;
        w.stay   = STEP_V1;
      end
      STEP_V1: begin
        w.dp.upd    = 1'b1;
        w.dp.sel_v1 = 1'b1;
        w.cond      = COND_LAST_RND;
        w.go        = STEP_EMIT;
        w.stay      = STEP_V0;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_FREE;
        w.go   = STEP_IDLE;
        w.stay = STEP_EMIT;
      end
      default: begin
        w.cond = COND_ALWAYS;
        w.go   = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/tcmk_datapath.sv =====
// TEA round datapath: v0/v1/sum registers and one shared half-round unit.
module tcmk_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcmk_pkg::dp_ctrl_t  ctrl_i,
  input  logic [63:0]         ctr_block_i,
  input  logic [31:0]         key_word_0_i,
  input  logic [31:0]         key_word_1_i,
  input  logic [31:0]         key_word_2_i,
  input  logic [31:0]         key_word_3_i,
  output logic [63:0]         keystream_o
);

  logic [31:0] v0_q, v0_d;
  logic [31:0] v1_q, v1_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] x, ka, kb, acc, f_val;

  // Shared F: ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb)
  always_comb begin
    x     = ctrl_i.sel_v1 ? v0_q : v1_q;
    ka    = ctrl_i.sel_v1 ? key_word_2_i : key_word_0_i;
    kb    = ctrl_i.sel_v1 ? key_word_3_i : key_word_1_i;
    acc   = ctrl_i.sel_v1 ? v1_q : v0_q;
    f_val = ((x << 4) + ka) ^ (x + sum_q) ^ ((x >> 5) + kb);
  end

  always_comb begin
    v0_d  = v0_q;
    v1_d  = v1_q;
    sum_d = sum_q;
    if (ctrl_i.load) begin
      v0_d  = ctr_block_i[31:0];
      v1_d  = ctr_block_i[63:32];
      sum_d = tcmk_pkg::TeaDelta;  // sum already stepped for round one
    end else if (ctrl_i.upd) begin
      if (ctrl_i.sel_v1) begin
        v1_d  = acc + f_val;
        sum_d = sum_q + tcmk_pkg::TeaDelta;
      end else begin
        v0_d = acc + f_val;
      end
    end
  end

  // sum cleared at reset; v0/v1 are always loaded before a half round uses them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v0_q <= v0_d;
    v1_q <= v1_d;
  end

  assign keystream_o = {v1_q, v0_q};

endmodule

// ===== hw/rtl/tea_counter_mode_keystream.sv =====
// TEA counter-mode keystream unit: sequencer, configuration, block counter and output register.
// The accepted block is loaded, ROUNDS pairs of v0 and v1 half rounds follow, and the emit step
//   writes the result beat to the output register once that register is free. The pace is set
//   by the single shared half-round unit, one v0 or v1 update per cycle.
// One block is in flight; the next input is taken while a finished beat waits at the output.
// Reset (async, active low): keys, nonce and block counter to zero, sequencer to idle,
//   output register empty.
module tea_counter_mode_keystream #(
  parameter int ROUNDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_block_i,
  input  logic        last_block_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_block_o,
  output logic        last_out_o
);

  localparam int RCW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
  localparam logic [RCW-1:0] LastRnd = RCW'(ROUNDS - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] key0_q, key1_q, key2_q, key3_q;
  logic [63:0] nonce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q  <= '0;
      key1_q  <= '0;
      key2_q  <= '0;
      key3_q  <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tcmk_pkg::CFG_KEY0:  key0_q  <= cfg_data_i[31:0];
        tcmk_pkg::CFG_KEY1:  key1_q  <= cfg_data_i[31:0];
        tcmk_pkg::CFG_KEY2:  key2_q  <= cfg_data_i[31:0];
        tcmk_pkg::CFG_KEY3:  key3_q  <= cfg_data_i[31:0];
        tcmk_pkg::CFG_NONCE: nonce_q <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Microcode sequencer
  // ---------------------------------------------------------------------------
  tcmk_pkg::step_e  step_q, step_d;
  tcmk_pkg::uword_t uw;
  logic             cond_true;
  logic [RCW-1:0]   rnd_q, rnd_d;
  logic             out_free;
  logic             in_accept;

  assign uw        = tcmk_pkg::ucode(step_q);
  assign in_stall_o = (step_q != tcmk_pkg::STEP_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  // output register can take a beat if empty or being drained this cycle
  assign out_free  = !out_valid_o || !out_stall_i;

  // next step
  always_comb begin
    unique case (uw.cond)
      tcmk_pkg::COND_ALWAYS:   cond_true = 1'b1;
      tcmk_pkg::COND_IN_VALID: cond_true = in_valid_i;
      tcmk_pkg::COND_LAST_RND: cond_true = (rnd_q == LastRnd);
      tcmk_pkg::COND_OUT_FREE: cond_true = out_free;
      default:                 cond_true = 1'b0;
    endcase
    step_d = cond_true ? uw.go : uw.stay;
  end

  // round counter, stepped on each v1 half round
  always_comb begin
    rnd_d = rnd_q;
    if (uw.dp.load) begin
      rnd_d = '0;
    end else if (uw.dp.upd && uw.dp.sel_v1) begin
      rnd_d = rnd_q + RCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= tcmk_pkg::STEP_IDLE;
      rnd_q  <= '0;
    end else begin
      step_q <= step_d;
      rnd_q  <= rnd_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Block latch and counter block
  // ---------------------------------------------------------------------------
  logic [63:0] data_q;
  logic        last_q;
  logic [31:0] cnt_q, cnt_d;
  logic [63:0] ctr_block;
  logic [63:0] keystream;
  logic        emit_now;

  assign ctr_block = nonce_q ^ {32'd0, cnt_q};
  assign emit_now  = uw.emit && out_free;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      data_q <= data_block_i;
      last_q <= last_block_i;
    end
  end

  // counter moves once the block's result is issued
  always_comb begin
    cnt_d = cnt_q;
    if (emit_now) begin
      cnt_d = last_q ? 32'd0 : cnt_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Round datapath
  // ---------------------------------------------------------------------------
  tcmk_pkg::dp_ctrl_t dp_ctrl;

  // load only on the accepting edge so the latched state holds while idle
  always_comb begin
    dp_ctrl      = uw.dp;
    dp_ctrl.load = uw.dp.load && in_accept;
  end

  tcmk_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dp_ctrl),
    .ctr_block_i  (ctr_block),
    .key_word_0_i (key0_q),
    .key_word_1_i (key1_q),
    .key_word_2_i (key2_q),
    .key_word_3_i (key3_q),
    .keystream_o  (keystream)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  logic [63:0] out_block_q;
  logic        last_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_now) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_block_q <= data_q ^ keystream;
      last_out_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_block_o = out_block_q;
  assign last_out_o  = last_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a pending beat is never overwritten: emit step holds while output is stalled
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == tcmk_pkg::STEP_EMIT && out_valid_q && out_stall_i)
      |=> (step_q == tcmk_pkg::STEP_EMIT))
    else $error("emit step left while output beat stalled");

  // an accepted block starts at round zero with a v0 half round
  a_start_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (rnd_q == '0 && step_q == tcmk_pkg::STEP_V0))
    else $error("block did not start at round zero");

  // issuing a last block returns the counter to zero
  a_cnt_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_now && last_q) |=> (cnt_q == 32'd0 && out_valid_q))
    else $error("block counter not restarted after last block");
`endif

endmodule

// ===== sim/tea_counter_mode_keystream_tb.sv =====
// Self-checking testbench for the TEA counter-mode keystream unit.
`timescale 1ns / 100ps

module tea_counter_mode_keystream_tb;

  // Default round count; the local predictor uses the same value.
  localparam int ROUNDS = 1024;
  // Cycles with no beat on either channel before the run is abandoned.
  // Worst correct case is one full block plus the longest gap on each side,
  // so this leaves a wide margin.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned LongGapMax = 2500;
  // Highest index the 3-bit register address can carry; anything above
  // CFG_NONCE is not a register and must be ignored.
  localparam logic [2:0] CfgIdxMax = 3'd7;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned ItemsPerPhase = 70;

  typedef struct packed {
    logic [63:0] blk;
    logic        last;
  } block_beat_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // block ports; the inputs are all known from time zero
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_block_i = '0;
  logic        last_block_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] out_block_o;
  logic        last_out_o;

  tea_counter_mode_keystream #(
    .ROUNDS(ROUNDS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_block_i(data_block_i),
    .last_block_i(last_block_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_block_o (out_block_o),
    .last_out_o  (last_out_o)
  );

  // Local copy of the unit's state: key words, nonce, block index.
  logic [31:0] key_q [4] = '{default: '0};
  logic [63:0] nonce_q = '0;
  logic [31:0] blk_idx_q = '0;

  block_beat_t pending_blocks[$];   // input beats waiting for the driver
  block_beat_t expected_blocks[$];  // predicted output beats, oldest first

  int unsigned items_queued = 0;
  int unsigned beats_checked = 0;
  int unsigned err_count = 0;
  bit          idle_on = 1'b0;     // random gaps and stalls enabled
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  // TEA encipherment of one counter block; {v1, v0} out.
  function automatic logic [63:0] tea_ctr_keystream(input logic [63:0] ctr_blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
    v0  = ctr_blk[31:0];
    v1  = ctr_blk[63:32];
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      sum += tcmk_pkg::TeaDelta;
      v0  += ((v1 << 4) + key_q[0]) ^ (v1 + sum) ^ ((v1 >> 5) + key_q[1]);
      v1  += ((v0 << 4) + key_q[2]) ^ (v0 + sum) ^ ((v0 >> 5) + key_q[3]);
    end
    return {v1, v0};
  endfunction

  // Mostly short gaps, now and then a long one that spans a good part of
  // (or more than) a block's computation, so it lands on any phase.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (!idle_on || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(40, 4);
    return $urandom_range(LongGapMax, 41);
  endfunction

  function automatic logic [63:0] pick_word64();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ERROR %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Register write: only issued while the unit is idle, so the local copy is
  // updated at once. A key word keeps its low 32 bits; unknown indexes do nothing.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      tcmk_pkg::CFG_KEY0:  key_q[0] = val[31:0];
      tcmk_pkg::CFG_KEY1:  key_q[1] = val[31:0];
      tcmk_pkg::CFG_KEY2:  key_q[2] = val[31:0];
      tcmk_pkg::CFG_KEY3:  key_q[3] = val[31:0];
      tcmk_pkg::CFG_NONCE: nonce_q = val;
      default:   ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_block(input logic [63:0] blk, input logic last);
    pending_blocks.push_back('{blk: blk, last: last});
    items_queued++;
  endtask

  // Hold off until every queued block has come back out.
  task automatic drain();
    wait (beats_checked == items_queued);
    @(posedge clk_i);
  endtask

  // Input driver: predicts on each accepted beat, then presents the next
  // block or idles. Payload only changes once the current beat is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    block_beat_t nxt;
    block_beat_t want;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      data_block_i <= '0;
      last_block_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        want.blk  = data_block_i ^ tea_ctr_keystream(nonce_q ^ {32'h0, blk_idx_q});
        want.last = last_block_i;
        expected_blocks.push_back(want);
        // end of message restarts the count, otherwise it steps (wrapping)
        blk_idx_q = last_block_i ? '0 : blk_idx_q + 32'd1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_blocks.size() > 0) begin
          nxt = pending_blocks.pop_front();
          in_valid_i   <= 1'b1;
          data_block_i <= nxt.blk;
          last_block_i <= nxt.last;
          in_gap = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random back-pressure, and each taken beat is checked
  // against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    block_beat_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected beat", out_block_o, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (out_block_o !== want.blk) report_mismatch("out_block", out_block_o, want.blk);
          if (last_out_o !== want.last) report_mismatch("last_out", 64'(last_out_o),
                                                        64'(want.last));
          beats_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if ($urandom_range(7) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: abandon the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t ERROR watchdog: no beat for %0d cycles", $realtime, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned msg_left;
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset configuration (all keys and nonce zero), no idling.
    queue_block(64'h0, 1'b0);
    queue_block('1, 1'b0);
    queue_block(64'h5555_5555_5555_5555, 1'b0);
    queue_block(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);   // end of message
    queue_block(64'h0000_0000_0000_0001, 1'b1);   // one-block message
    queue_block(64'h8000_0000_0000_0000, 1'b0);
    queue_block(64'hFFFF_FFFF_0000_0000, 1'b0);   // message left open
    drain();

    // Mid-message change: wide values on the keys (top half must be dropped),
    // nonce all ones, then writes to non-existent registers that must not land.
    cfg_write(tcmk_pkg::CFG_KEY0, '1);
    cfg_write(tcmk_pkg::CFG_KEY1, 64'hDEAD_BEEF_FFFF_FFFF);
    cfg_write(tcmk_pkg::CFG_KEY2, '1);
    cfg_write(tcmk_pkg::CFG_KEY3, 64'h1234_5678_FFFF_FFFF);
    cfg_write(tcmk_pkg::CFG_NONCE, '1);
    for (int i = tcmk_pkg::CFG_NONCE + 1; i <= CfgIdxMax; i++) begin
      cfg_write(3'(i), {$urandom, $urandom});
    end
    queue_block(64'h0000_0000_FFFF_FFFF, 1'b0);
    queue_block({$urandom, $urandom}, 1'b1);
    queue_block('1, 1'b0);
    drain();

    // Other extreme: keys zero, KEY0 and KEY2 with top halves set, nonce zero.
    cfg_write(tcmk_pkg::CFG_KEY0, 64'hFFFF_FFFF_0000_0000);
    cfg_write(tcmk_pkg::CFG_KEY1, 64'h0);
    cfg_write(tcmk_pkg::CFG_KEY2, 64'hFFFF_FFFF_0000_0000);
    cfg_write(tcmk_pkg::CFG_KEY3, 64'h0);
    cfg_write(tcmk_pkg::CFG_NONCE, 64'h0);
    queue_block(64'h0, 1'b0);
    queue_block('1, 1'b1);
    queue_block({$urandom, $urandom}, 1'b0);
    drain();

    // Random phases: fresh settings, then messages of random length with
    // random content. Idling is on in most phases, off in some.
    msg_left = 0;
    for (int p = 0; p < RandPhases; p++) begin
      for (int i = tcmk_pkg::CFG_KEY0; i <= tcmk_pkg::CFG_NONCE; i++) begin
        if ($urandom_range(1)) cfg_write(3'(i), pick_word64());
      end
      if ($urandom_range(2) == 0) begin
        cfg_write(3'($urandom_range(CfgIdxMax, tcmk_pkg::CFG_NONCE + 1)),
                  {$urandom, $urandom});
      end
      idle_on = ($urandom_range(3) != 0);
      for (n = 0; n < ItemsPerPhase; n++) begin
        if (msg_left == 0) begin
          case ($urandom_range(19))
            0:       msg_left = $urandom_range(60, 31);
            1, 2, 3: msg_left = $urandom_range(30, 9);
            default: msg_left = $urandom_range(8, 1);
          endcase
        end
        msg_left--;
        queue_block(($urandom_range(19) == 0) ? pick_word64() : {$urandom, $urandom},
                    msg_left == 0);
      end
      // wait for everything to come back before touching the registers
      drain();
    end

    // Let any stray beat show itself, then give the verdict.
    repeat (2 * ROUNDS + 8) @(posedge clk_i);
    if (expected_blocks.size() != 0) report_mismatch("beats never seen",
                                                     64'(expected_blocks.size()), '0);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tcmk_pkg.sv
hw/rtl/tcmk_datapath.sv
hw/rtl/tea_counter_mode_keystream.sv
sim/tea_counter_mode_keystream_tb.sv
